// ===== src/bis_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_pkg
// Shared constants and word types of the binary insertion sorter.
// ----------------------------------------------------------------------------
package bis_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last_in;
    } in_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     last_out;
        logic                     dropped;
    } out_word_t;

    // Access group from the sequencer to the store
    typedef struct packed {
        logic                     we;
        logic [ADDR_W-1:0]        waddr;
        logic signed [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0]        raddr;
    } store_req_t;

endpackage

// ===== src/bis_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_store
// Sorted value store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bis_store (
    input  logic                              clk,
    input  bis_pkg::store_req_t               req,
    output logic signed [bis_pkg::DATA_W-1:0] rdata
);
    import bis_pkg::*;

    logic signed [DATA_W-1:0] mem [MAX_ITEMS];
    logic signed [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/binary_insertion_sorter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_insertion_sorter
// Sorts a set of signed 32-bit words by binary search and insertion.
// ----------------------------------------------------------------------------
// Usage:
//   Input: a word (item.value, item.last_in) is taken when start is high and
//   busy is low. Each word is inserted into a sorted store of MAX_ITEMS
//   entries: a binary search (up to 6 probes) finds the slot after any equal
//   entries, then entries above it move up one place (each moved entry is
//   read from the store, then written back one address higher). At most 63
//   entries move in one insert. A word arriving while the store is full is
//   discarded and marks its set as having lost words.
//   Output: the word with last_in set (inserted first if room) starts the
//   drain: every stored value leaves in ascending order on result, with
//   valid high for one cycle. last_out marks the final one,
//   dropped is set on all of them if the set lost words. The receiver cannot
//   stall; busy stays high until the drain ends and the store is empty.
//   Reset: count and overflow flag clear, store contents are not cleared.
// ----------------------------------------------------------------------------
module binary_insertion_sorter (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  bis_pkg::in_word_t item,
    output logic              busy,
    output bis_pkg::out_word_t result,
    output logic              valid
);
    import bis_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SRD   = 3'd1;
    localparam logic [2:0] S_SCMP  = 3'd2;
    localparam logic [2:0] S_SHRD  = 3'd3;
    localparam logic [2:0] S_SHWR  = 3'd4;
    localparam logic [2:0] S_ORD   = 3'd5;
    localparam logic [2:0] S_OEMIT = 3'd6;

    logic [2:0]               state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     ovf_reg, ovf_next;
    logic [CNT_W-1:0]         lo_reg, lo_next;
    logic [CNT_W-1:0]         hi_reg, hi_next;
    logic [CNT_W-1:0]         j_reg, j_next;
    logic [ADDR_W-1:0]        k_reg, k_next;
    logic signed [DATA_W-1:0] value_reg, value_next;
    logic                     last_reg, last_next;

    logic [CNT_W-1:0]         mid;
    logic [CNT_W-1:0]         jm1;
    logic                     k_final;
    logic signed [DATA_W-1:0] rdata;
    store_req_t               req;

    assign mid     = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign jm1     = j_reg - CNT_W'(1);
    assign k_final = (CNT_W'(k_reg) == count_reg - CNT_W'(1));

    bis_store u_store (
        .clk   (clk),
        .req   (req),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        value_next = value_reg;
        last_next  = last_reg;
        req.we     = 1'b0;
        req.waddr  = lo_reg[ADDR_W-1:0];
        req.wdata  = value_reg;
        req.raddr  = mid[ADDR_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    value_next = item.value;
                    last_next  = item.last_in;
                    lo_next    = '0;
                    hi_next    = count_reg;
                    k_next     = '0;
                    if (count_reg >= CNT_W'(MAX_ITEMS))
                    begin
                        ovf_next = 1'b1;
                        if (item.last_in)
                        begin
                            state_next = S_ORD;
                        end
                    end
                    else
                    begin
                        state_next = S_SRD;
                    end
                end
            end
            S_SRD:
            begin
                if (lo_reg < hi_reg)
                begin
                    state_next = S_SCMP;
                end
                else
                begin
                    j_next     = count_reg;
                    state_next = S_SHRD;
                end
            end
            S_SCMP:
            begin
                // first entry greater than the value bounds the slot
                if (rdata > value_reg)
                begin
                    hi_next = mid;
                end
                else
                begin
                    lo_next = mid + CNT_W'(1);
                end
                state_next = S_SRD;
            end
            S_SHRD:
            begin
                req.raddr = jm1[ADDR_W-1:0];
                if (j_reg > lo_reg)
                begin
                    state_next = S_SHWR;
                end
                else
                begin
                    req.we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    state_next = last_reg ? S_ORD : S_IDLE;
                end
            end
            S_SHWR:
            begin
                req.we     = 1'b1;
                req.waddr  = j_reg[ADDR_W-1:0];
                req.wdata  = rdata;
                j_next     = jm1;
                state_next = S_SHRD;
            end
            S_ORD:
            begin
                req.raddr  = k_reg;
                state_next = S_OEMIT;
            end
            S_OEMIT:
            begin
                if (k_final)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                    state_next = S_IDLE;
                end
                else
                begin
                    k_next     = k_reg + ADDR_W'(1);
                    state_next = S_ORD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        j_reg     <= j_next;
        k_reg     <= k_next;
        value_reg <= value_next;
        last_reg  <= last_next;
    end

    assign busy                = (state_reg != S_IDLE);
    assign valid               = (state_reg == S_OEMIT);
    assign result.sorted_value = rdata;
    assign result.last_out     = k_final;
    assign result.dropped      = ovf_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ITEMS))
        else $error("stored count above capacity");

    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> busy && count_reg != '0)
        else $error("result emitted from empty or idle sorter");

    a_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
        valid && result.last_out |=> !busy && count_reg == '0 && !ovf_reg)
        else $error("store not emptied after final word");

    a_accept_room: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && count_reg < CNT_W'(MAX_ITEMS) |=> busy)
        else $error("accepted word not inserted");
`endif

endmodule

// ===== sim/tb_binary_insertion_sorter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_insertion_sorter
// Self-checking bench for the binary insertion sorter.
// ----------------------------------------------------------------------------
// Sets of signed words go in through the start/busy handshake. A scoreboard
// keeps its own sorted copy of each set and, on the word marked last, queues
// the ascending results with their last and dropped flags. Every strobed
// result is checked against the oldest queued one. Stimulus: a few directed
// sets (extremes, equal values, ordered runs), then random sets of mixed
// size, some filling the store and overflowing it, with random sender gaps.
// ----------------------------------------------------------------------------
module tb_binary_insertion_sorter;

    import bis_pkg::*;

    localparam int WORD_TARGET = 360;
    localparam int QUIET_LIMIT = 3000;
    localparam int TAIL_CYCLES = 300;

    // ------------------------------------------------------------------------
    // Scoreboard: sorted copy of the current set plus the queue of results
    // still due from the block.
    // ------------------------------------------------------------------------
    class sort_scoreboard;
        logic signed [DATA_W-1:0] held[$];
        out_word_t                due_words[$];
        bit                       lost_word;
        int                       mismatches;
        int                       checked;
        int                       sets_done;
        int                       sets_lost;

        function void note_word(in_word_t w);
            out_word_t r;
            int        lo;
            int        hi;
            int        mid;
            if (held.size() >= MAX_ITEMS) begin
                lost_word = 1'b1;
            end
            else begin
                // first slot whose entry is greater: equal values stay in order
                lo = 0;
                hi = held.size();
                while (lo < hi) begin
                    mid = (lo + hi) / 2;
                    if (held[mid] > w.value)
                        hi = mid;
                    else
                        lo = mid + 1;
                end
                held.insert(lo, w.value);
            end
            if (w.last_in) begin
                foreach (held[k]) begin
                    r.sorted_value = held[k];
                    r.last_out     = (k == held.size() - 1);
                    r.dropped      = lost_word;
                    due_words.push_back(r);
                end
                sets_done++;
                if (lost_word)
                    sets_lost++;
                held.delete();
                lost_word = 1'b0;
            end
        endfunction

        function void check_word(out_word_t r);
            out_word_t e;
            if (due_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result value=%0d last=%0b dropped=%0b",
                             r.sorted_value, r.last_out, r.dropped);
                return;
            end
            e = due_words.pop_front();
            checked++;
            if (r.sorted_value !== e.sorted_value || r.last_out !== e.last_out ||
                r.dropped !== e.dropped) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d exp value=%0d last=%0b dropped=%0b, got value=%0d last=%0b dropped=%0b",
                             checked, e.sorted_value, e.last_out, e.dropped,
                             r.sorted_value, r.last_out, r.dropped);
            end
        endfunction

        function int pending();
            return due_words.size();
        endfunction
    endclass

    logic      clk   = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    in_word_t  item  = '0;
    logic      busy;
    out_word_t result;
    logic      valid;

    sort_scoreboard sb;
    int words_sent  = 0;
    int quiet_count = 0;

    binary_insertion_sorter dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .result (result),
        .valid  (valid)
    );

    always #1 clk = ~clk;

    // Monitor: takes accepted words and results at the same edge, so the
    // expectation of a set is in place before any of its results is checked.
    always @(posedge clk) begin
        if (rst_n) begin
            if (start && busy === 1'b0) begin
                sb.note_word(item);
                quiet_count = 0;
            end
            else if (valid !== 1'b1) begin
                quiet_count++;
            end
            if (valid === 1'b1) begin
                sb.check_word(result);
                quiet_count = 0;
            end
            if (quiet_count >= QUIET_LIMIT) begin
                $display("watchdog: no activity for %0d cycles", QUIET_LIMIT);
                $display("binary_insertion_sorter test failed");
                $finish;
            end
        end
    end

    // Called right after a rising edge; returns at the edge that takes the word.
    task automatic send_word(input logic signed [DATA_W-1:0] v, input logic lst,
                             input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start         <= 1'b1;
        item.value    <= v;
        item.last_in  <= lst;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        words_sent++;
    endtask

    // Sender holds off until the last result of every closed set is out.
    task automatic hold_until_drained();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [DATA_W-1:0] draw_value(input int style);
        case (style)
            0: return $urandom_range(0, 8) - 4;          // many equal values
            1: begin
                case ($urandom_range(0, 4))
                    0: return 32'sh7fffffff;
                    1: return 32'sh80000000;
                    2: return 0;
                    3: return -1;
                    default: return 1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic send_list(input logic signed [DATA_W-1:0] vals[$]);
        foreach (vals[k])
            send_word(vals[k], k == vals.size() - 1, $urandom_range(0, 3));
    endtask

    task automatic send_random_set(input int size, input bit tight);
        int style;
        int gap;
        style = $urandom_range(0, 5);
        for (int k = 0; k < size; k++) begin
            gap = tight ? 0 : $urandom_range(0, 12);
            send_word(draw_value(style < 2 ? style : 2), k == size - 1, gap);
        end
    endtask

    initial begin
        int  set_idx;
        int  size;
        logic signed [DATA_W-1:0] vals[$];
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed sets
        vals = '{32'sd7};
        send_list(vals);
        vals = '{32'sh7fffffff, 32'sh80000000, 0, -1, 1, 32'sh80000001,
                 32'sh7ffffffe, 0};
        send_list(vals);
        hold_until_drained();
        vals = '{3, 3, -3, 3, -3, 3};
        send_list(vals);
        vals = '{10, 9, 8, 7, 6};
        send_list(vals);
        vals = '{1, 2, 3, 4};
        send_list(vals);

        // random sets; two forced sizes hit a full store and an overflow
        set_idx = 0;
        while (words_sent < WORD_TARGET) begin
            if (set_idx == 3)
                size = MAX_ITEMS;
            else if (set_idx == 6)
                size = MAX_ITEMS + 2;
            else if ($urandom_range(0, 11) == 0)
                size = $urandom_range(MAX_ITEMS - 2, MAX_ITEMS + 6);
            else
                size = $urandom_range(1, 10);
            if (set_idx == 2 || $urandom_range(0, 5) == 0)
                hold_until_drained();
            send_random_set(size, $urandom_range(0, 3) == 0);
            set_idx++;
        end

        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d words in %0d sets, %0d with lost words; %0d results checked",
                 words_sent, sb.sets_done, sb.sets_lost, sb.checked);
        if (sb.mismatches > 10)
            $display("%0d mismatches in total", sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0 && sb.held.size() == 0) begin
            $display("binary_insertion_sorter test passed");
        end
        else begin
            $display("binary_insertion_sorter test failed");
        end
        $finish;
    end

endmodule

// ===== binary_insertion_sorter.f =====
src/bis_pkg.sv
src/bis_store.sv
src/binary_insertion_sorter.sv
sim/tb_binary_insertion_sorter.sv
